@@ sv/lpct_pkg.sv @@
// Shared types, codes and hash stages of the linear probe count table.
package lpct_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int POS_W = IDX_W + 1;
  localparam int KEY_W = 64;
  localparam int VAL_W = 31;
  localparam int TOT_W = 11;

  localparam logic [2:0] K_INC = 3'd0;
  localparam logic [2:0] K_INS = 3'd1;
  localparam logic [2:0] K_LKP = 3'd2;
  localparam logic [2:0] K_RST = 3'd3;
  localparam logic [2:0] K_NXT = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] new_value;
    logic [IDX_W-1:0] home;
  } work_t;

  function automatic logic [63:0] hash_a(input logic [63:0] x);
    logic [63:0] a, b;
    a = x ^ (x >> 14);
    b = (~a) + (a << 18);
    return b ^ (b >> 31);
  endfunction

  function automatic logic [63:0] hash_b(input logic [63:0] x);
    return (x << 4) + (x << 2) + x;
  endfunction

  function automatic logic [IDX_W-1:0] hash_c(input logic [63:0] x);
    logic [63:0] a, b, c;
    a = x ^ (x >> 11);
    b = a + (a << 6);
    c = b ^ (b >> 22);
    return c[IDX_W-1:0];
  endfunction

endpackage

@@ sv/lpct_if.sv @@
// Request and response channel interfaces.
interface lpct_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] key;
  logic [30:0] new_value;
  modport source (output valid, kind, key, new_value, input ready);
  modport sink (input valid, kind, key, new_value, output ready);
endinterface

interface lpct_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [63:0] slot_key;
  logic [30:0] slot_value;
  logic [10:0] key_count;
  modport source (output valid, status, found, slot_key, slot_value, key_count, input ready);
  modport sink (input valid, status, found, slot_key, slot_value, key_count, output ready);
endinterface

@@ sv/linear_probe_count_table_top.sv @@
// Top level of the linear probe count table.
// Counting hash table of 1024 slots, 64-bit keys, 31-bit counts.
// req channel: one beat per operation (kind, key, new_value);
// rsp channel: exactly one beat per request, in request order.
// Requests pass a three-stage hash pipeline into a four-entry queue;
// the back end then walks the slot memories one slot at a time
// (registered read, then compare and write).
// Increment, insert and lookup probe from the home slot onward;
// restart, unused kinds and scan next at the end answer without a probe.
// Scan next examines slots from the scan position until an occupied one.
// The back end takes a new item from the queue only when idle, so it
// finishes one item before it takes the next.
// After reset a clearing pass zeroes the count memory, with req.ready
// low throughout.
// When rsp.ready is low the response register holds its beat; the back
// end stops at its next result, and the queue and hash pipeline fill
// before req.ready drops.
module linear_probe_count_table_top (
  input logic clk,
  input logic rst,
  lpct_req_if.sink   req,
  lpct_rsp_if.source rsp
);
  logic            f_valid, f_ready, in_ready, clearing;
  lpct_pkg::work_t f_data;
  logic            q_valid, q_ready;
  lpct_pkg::work_t q_data;

  assign req.ready = in_ready && !clearing;

  lpct_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(req.valid && !clearing), .in_ready(in_ready),
    .in_kind(req.kind), .in_key(req.key), .in_new_value(req.new_value),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  lpct_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  lpct_back u_back (
    .clk(clk), .rst(rst),
    .work_valid(q_valid), .work_ready(q_ready), .work(q_data),
    .clearing(clearing),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_found(rsp.found), .rsp_key(rsp.slot_key),
    .rsp_value(rsp.slot_value), .rsp_count(rsp.key_count)
  );
endmodule

@@ sv/lpct_front.sv @@
// Front end: three-stage hash pipeline that tags each request with its home slot.
module lpct_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [63:0]         in_key,
  input  logic [30:0]         in_new_value,
  output logic                out_valid,
  input  logic                out_ready,
  output lpct_pkg::work_t     out_data
);
  logic        v1, v2, v3;
  logic [2:0]  k1, k2, k3;
  logic [63:0] key1, key2, key3;
  logic [30:0] nv1, nv2, nv3;
  logic [63:0] h1, h2;
  logic [lpct_pkg::IDX_W-1:0] h3;
  logic        mv1, mv2, mv3;

  assign mv3 = !v3 || out_ready;
  assign mv2 = !v2 || mv3;
  assign mv1 = !v1 || mv2;
  assign in_ready = mv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (mv1) v1 <= in_valid;
      if (mv2) v2 <= v1;
      if (mv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      k1 <= in_kind; key1 <= in_key; nv1 <= in_new_value;
      h1 <= lpct_pkg::hash_a(in_key);
    end
    if (mv2) begin
      k2 <= k1; key2 <= key1; nv2 <= nv1;
      h2 <= lpct_pkg::hash_b(h1);
    end
    if (mv3) begin
      k3 <= k2; key3 <= key2; nv3 <= nv2;
      h3 <= lpct_pkg::hash_c(h2);
    end
  end

  assign out_valid = v3;
  assign out_data  = '{kind: k3, key: key3, new_value: nv3, home: h3};
endmodule

@@ sv/lpct_fifo.sv @@
// Four-entry queue between front end and back end.
module lpct_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lpct_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lpct_pkg::work_t pop_data
);
  lpct_pkg::work_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       do_push, do_pop;

  assign push_ready = cnt != 3'd4;
  assign pop_valid  = cnt != 3'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 2'd1;
      if (do_pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, do_push} - {2'd0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end
endmodule

@@ sv/lpct_back.sv @@
// Back end: slot memories, probe and scan sequencer, response register.
module lpct_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            work_valid,
  output logic            work_ready,
  input  lpct_pkg::work_t work,
  output logic            clearing,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output logic [1:0]      rsp_status,
  output logic            rsp_found,
  output logic [63:0]     rsp_key,
  output logic [30:0]     rsp_value,
  output logic [10:0]     rsp_count
);
  localparam int IW = lpct_pkg::IDX_W;
  localparam int PW = lpct_pkg::POS_W;
  localparam logic [1:0] S_CLR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD = 2'd2;
  localparam logic [1:0] S_CHK = 2'd3;
  localparam logic [IW-1:0] LAST = IW'(lpct_pkg::SLOTS - 1);

  logic [30:0] counts [lpct_pkg::SLOTS];
  logic [63:0] keys [lpct_pkg::SLOTS];
  logic [30:0] rd_cnt;
  logic [63:0] rd_key;

  logic [1:0]  state, state_next;
  logic [IW-1:0] clr_idx, addr, addr_next, probes, probes_next;
  logic [PW-1:0] scan_pos, scan_pos_next;
  logic [10:0] total, total_next;
  lpct_pkg::work_t cur;
  logic        fin_ok, pop, hit;
  logic        emit, e_found;
  logic [1:0]  e_status;
  logic [63:0] e_key;
  logic [30:0] e_val;
  logic        cnt_we, key_we;
  logic [IW-1:0] cnt_wa;
  logic [30:0] cnt_wd, inc_val;

  assign fin_ok = !rsp_valid || rsp_ready;
  assign pop = (state == S_IDLE) && work_valid && fin_ok;
  assign work_ready = pop;
  assign clearing = state == S_CLR;
  assign hit = (rd_cnt == '0) || (rd_key == cur.key);
  assign inc_val = (rd_cnt == lpct_pkg::VAL_MAX) ? rd_cnt : rd_cnt + 31'd1;

  always_comb begin
    state_next = state; addr_next = addr; probes_next = probes;
    scan_pos_next = scan_pos; total_next = total;
    emit = 1'b0; e_status = lpct_pkg::ST_OK; e_found = 1'b0; e_key = '0; e_val = '0;
    cnt_we = 1'b0; key_we = 1'b0; cnt_wa = addr; cnt_wd = '0;
    unique case (state)
      S_CLR: begin
        cnt_we = 1'b1; cnt_wa = clr_idx;
        if (clr_idx == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pop) begin
          priority if (work.kind == lpct_pkg::K_INC || work.kind == lpct_pkg::K_INS ||
                       work.kind == lpct_pkg::K_LKP) begin
            addr_next = work.home; probes_next = '0; state_next = S_RD;
          end else if (work.kind == lpct_pkg::K_RST) begin
            scan_pos_next = '0; emit = 1'b1;
          end else if (work.kind == lpct_pkg::K_NXT) begin
            if (scan_pos[PW-1]) begin
              emit = 1'b1; e_status = lpct_pkg::ST_END;
            end else begin
              addr_next = scan_pos[IW-1:0]; state_next = S_RD;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (cur.kind == lpct_pkg::K_NXT) begin
          if (rd_cnt != '0) begin
            if (fin_ok) begin
              emit = 1'b1; e_found = 1'b1; e_key = rd_key; e_val = rd_cnt;
              scan_pos_next = {1'b0, addr} + PW'(1); state_next = S_IDLE;
            end
          end else if (addr == LAST) begin
            if (fin_ok) begin
              emit = 1'b1; e_status = lpct_pkg::ST_END;
              scan_pos_next = PW'(lpct_pkg::SLOTS); state_next = S_IDLE;
            end
          end else begin
            addr_next = addr + IW'(1); state_next = S_RD;
          end
        end else if (hit) begin
          if (fin_ok) begin
            emit = 1'b1; e_key = cur.key; state_next = S_IDLE;
            if (cur.kind != lpct_pkg::K_LKP && rd_cnt == '0) begin
              key_we = 1'b1;
              if (total != lpct_pkg::TOT_MAX) total_next = total + 11'd1;
            end
            priority if (cur.kind == lpct_pkg::K_INC) begin
              cnt_we = 1'b1; cnt_wd = inc_val; e_val = inc_val;
            end else if (cur.kind == lpct_pkg::K_INS) begin
              cnt_we = 1'b1; cnt_wd = cur.new_value; e_val = cur.new_value;
            end else begin
              e_found = rd_cnt != '0; e_val = rd_cnt;
            end
          end
        end else if (probes == LAST) begin
          if (fin_ok) begin
            emit = 1'b1; e_status = lpct_pkg::ST_FULL; e_key = cur.key; state_next = S_IDLE;
          end
        end else begin
          addr_next = addr + IW'(1); probes_next = probes + IW'(1); state_next = S_RD;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_idx <= '0; scan_pos <= '0; total <= '0; rsp_valid <= 1'b0;
    end else begin
      state <= state_next; scan_pos <= scan_pos_next; total <= total_next;
      if (state == S_CLR) clr_idx <= clr_idx + IW'(1);
      if (emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next; probes <= probes_next;
    if (pop) cur <= work;
    if (emit) begin
      rsp_status <= e_status; rsp_found <= e_found; rsp_key <= e_key;
      rsp_value <= e_val; rsp_count <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) counts[cnt_wa] <= cnt_wd;
    if (key_we) keys[addr] <= cur.key;
    rd_cnt <= counts[addr];
    rd_key <= keys[addr];
  end
endmodule

@@ sv/lpct_checker.sv @@
// Port-level checker for the linear probe count table, bound to the top level.
module lpct_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic        rsp_found,
  input logic [63:0] rsp_slot_key,
  input logic [30:0] rsp_slot_value
);
  a_clear_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing pass");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_key))
    else $error("stalled response beat changed");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("bad status");
  a_found_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_slot_value != '0 && rsp_status == lpct_pkg::ST_OK)
    else $error("hit with empty slot or bad status");
endmodule

bind linear_probe_count_table_top lpct_checker u_lpct_checker (
  .clk(clk), .rst(rst), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
  .rsp_found(rsp.found), .rsp_slot_key(rsp.slot_key), .rsp_slot_value(rsp.slot_value)
);
